FILE: rtl/gia_pkg.sv
// Shared types and codes for the grouped id allocator.
// Used by gia_map and grouped_id_allocator_top; depends on nothing.
package gia_pkg;

  localparam int ID_W   = 31;   // id and base width
  localparam int CNTC_W = 11;   // id_count register width
  localparam int CFG_W  = 31;   // widest config register
  localparam int CFGI_W = 1;    // config index width

  localparam logic [CFGI_W-1:0] CFG_BASE_ID  = 1'd0;
  localparam logic [CFGI_W-1:0] CFG_ID_COUNT = 1'd1;

  localparam logic OP_GET     = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_TAKEN = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

FILE: rtl/gia_map.sv
// Per-group free bitmap store for the grouped id allocator.
// One synchronous memory, one read and one write port; depends on gia_pkg.
module gia_map import gia_pkg::*; #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // an entry never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '1;

endmodule

FILE: rtl/grouped_id_allocator_top.sv
// Grouped id allocator, top level: request control, range check and encoders.
// Instantiates gia_map; depends on gia_pkg.
//
// A request is taken when start is high and busy is low. For each request, the
// accept cycle reads one group bitmap from the map memory, the next cycle
// modifies and writes it back, and the result is strobed on out_valid for one
// cycle right after that; a new request can be accepted in that same cycle, as
// busy is high only during the modify cycle of the memory's read-modify-write.
// The receiver cannot stall the result. No clearing pass is needed after reset:
// each map entry carries a valid bit and reads as all free until first written.
module grouped_id_allocator_top import gia_pkg::*; #(
  parameter int MAX_IDS    = 1024,
  parameter int GROUP_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [ID_W-1:0]   in_release_id,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_granted_id,
  output logic [1:0]        out_status,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int NUM_GROUPS = (MAX_IDS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int BIT_W  = $clog2(GROUP_SIZE);
  localparam int OFF_W  = $clog2(MAX_IDS);
  localparam int CNT_W  = $clog2(MAX_IDS + 1);
  localparam int DIV_SH = OFF_W + BIT_W;
  localparam int DIV_M  = ((2 ** DIV_SH) + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PROD_W = OFF_W + DIV_SH + 1;

  // configuration
  logic [ID_W-1:0]   base_id_r;
  logic [CNTC_W-1:0] id_count_r;
  logic [CNT_W-1:0]  cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r  <= '0;
      id_count_r <= CNTC_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_ID:  base_id_r  <= cfg_wdata[ID_W-1:0];
        CFG_ID_COUNT: id_count_r <= cfg_wdata[CNTC_W-1:0];
        default: ;
      endcase
    end
  end

  assign cnt = (32'(id_count_r) > 32'(MAX_IDS)) ? CNT_W'(MAX_IDS) : CNT_W'(id_count_r);

  // control
  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      S_EXEC:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // summary: group holds a free id
  logic [NUM_GROUPS-1:0] has_free_r, has_free_nxt;
  logic [NUM_GROUPS-1:0] gvalid, cand;
  logic [GRP_W-1:0]      get_grp;
  logic                  get_found;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gvalid[g] = (32'(g * GROUP_SIZE) < 32'(cnt));
    end
    cand      = has_free_r & gvalid;
    get_found = |cand;
    get_grp   = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (cand[g]) get_grp = GRP_W'(g);
    end
  end

  // release range check and offset split
  logic [ID_W-1:0]   rel_diff;
  logic              rel_in_range;
  logic [OFF_W-1:0]  rel_off;
  logic [PROD_W-1:0] rel_prod;
  logic [GRP_W-1:0]  rel_grp;

  always_comb begin
    rel_diff     = in_release_id - base_id_r;
    rel_in_range = (in_release_id >= base_id_r) && (32'(rel_diff) < 32'(cnt));
    rel_off      = rel_diff[OFF_W-1:0];
    // divide by group size through a reciprocal, exact for every offset width
    rel_prod     = PROD_W'(rel_off) * PROD_W'(DIV_M);
    rel_grp      = rel_prod[DIV_SH +: GRP_W];
  end

  // request registers
  logic             op_r;
  logic [GRP_W-1:0] grp_r;
  logic [OFF_W-1:0] off_r;
  status_t          pre_st_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      if (in_operation == OP_GET) begin
        grp_r    <= get_grp;
        pre_st_r <= get_found ? ST_OK : ST_FULL;
      end else begin
        grp_r    <= rel_grp;
        pre_st_r <= rel_in_range ? ST_OK : ST_RANGE;
      end
      off_r <= rel_off;
    end
  end

  // map memory
  logic [GROUP_SIZE-1:0] rd_word;
  logic                  wr_en;
  logic [GROUP_SIZE-1:0] wr_word;

  gia_map #(
    .DEPTH  (NUM_GROUPS),
    .WIDTH  (GROUP_SIZE),
    .ADDR_W (GRP_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr ((in_operation == OP_GET) ? get_grp : rel_grp),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (grp_r),
    .wr_data (wr_word)
  );

  // modify stage
  logic [CNT_W:0]        grp_lo;
  logic [CNT_W:0]        rem;
  logic [GROUP_SIZE-1:0] lane_ok, avail;
  logic [BIT_W-1:0]      get_bit, rel_bit;
  logic [OFF_W-1:0]      rel_bit_w;
  logic [ID_W-1:0]       res_id;
  status_t               res_st;

  always_comb begin
    grp_lo    = (CNT_W+1)'(32'(grp_r) * GROUP_SIZE);
    rem       = {1'b0, cnt} - grp_lo;
    for (int b = 0; b < GROUP_SIZE; b++) begin
      lane_ok[b] = (32'(b) < 32'(rem));
    end
    avail     = rd_word & lane_ok;
    get_bit   = '0;
    for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
      if (avail[b]) get_bit = BIT_W'(b);
    end
    rel_bit_w = off_r - OFF_W'(32'(grp_r) * GROUP_SIZE);
    rel_bit   = rel_bit_w[BIT_W-1:0];

    wr_en        = 1'b0;
    wr_word      = rd_word;
    has_free_nxt = has_free_r;
    res_id       = '0;
    res_st       = pre_st_r;

    if (state_r == S_EXEC && pre_st_r == ST_OK) begin
      if (op_r == OP_GET) begin
        if (avail == '0) begin
          // only the last partial group can land here
          res_st = ST_FULL;
        end else begin
          wr_en            = 1'b1;
          wr_word[get_bit] = 1'b0;
          if (wr_word == '0) has_free_nxt[grp_r] = 1'b0;
          res_id = base_id_r + ID_W'(grp_lo) + ID_W'(get_bit);
        end
      end else if (rd_word[rel_bit]) begin
        res_st = ST_NOT_TAKEN;
      end else begin
        wr_en               = 1'b1;
        wr_word[rel_bit]    = 1'b1;
        has_free_nxt[grp_r] = 1'b1;
      end
    end
  end

  logic            out_valid_r;
  logic [ID_W-1:0] out_id_r;
  status_t         out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_free_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      has_free_r  <= has_free_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      out_id_r <= res_id;
      out_st_r <= res_st;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_granted_id = out_id_r;
  assign out_status     = out_st_r;

  // checks
  a_res_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_EXEC)
    else $error("result beat without a modify cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("accepted request did not enter the modify cycle");

  a_id_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_id == '0)
    else $error("nonzero id on a failed request");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == S_EXEC && !accept)
    else $error("map write outside the modify cycle");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for grouped_id_allocator_top: directed and random get/release beats.
// Depends on gia_pkg and the allocator RTL. Expected results come from an in-bench id pool.
`timescale 1ns / 100ps

module testbench;
  import gia_pkg::*;

  localparam int MAX_IDS    = 1024;
  localparam int GROUP_SIZE = 32;
  localparam int NUM_GROUPS = (MAX_IDS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 230;
  localparam int NUM_PHASES  = 5;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [ID_W-1:0]   in_release_id;
  logic              out_valid;
  logic [ID_W-1:0]   out_granted_id;
  logic [1:0]        out_status;
  logic              cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  typedef struct {
    logic [ID_W-1:0] gid;
    status_t         st;
  } grant_t;

  // Mirror of the allocator: per-group free bits, group summary bits and config.
  class id_pool_model;
    bit [GROUP_SIZE-1:0] free_bits [NUM_GROUPS];
    bit                  group_open [NUM_GROUPS];
    bit [ID_W-1:0]       base;
    bit [CNTC_W-1:0]     count;
    grant_t              pending_grants[$];
    int errors, n_req, n_ok, n_full, n_range, n_not_taken;

    function new();
      foreach (free_bits[g]) begin
        free_bits[g] = '1;
        group_open[g] = 1'b1;
      end
      base = '0;
      count = 11'd1024;
    endfunction

    function void set_register(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_BASE_ID) base = val[ID_W-1:0];
      else if (idx == CFG_ID_COUNT) count = val[CNTC_W-1:0];
    endfunction

    function int unsigned span();
      return (count > MAX_IDS) ? MAX_IDS : count;
    endfunction

    function grant_t allocate_or_free(logic op, logic [ID_W-1:0] rid);
      grant_t r;
      int unsigned lim, rem, off;
      bit [GROUP_SIZE-1:0] usable;
      int grp, bit_i;
      r.gid = '0;
      r.st = ST_OK;
      lim = span();
      if (op == OP_GET) begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          if (!group_open[g]) continue;
          if (lim <= g * GROUP_SIZE) usable = '0;
          else begin
            rem = lim - g * GROUP_SIZE;
            usable = '1;
            if (rem < GROUP_SIZE) usable = usable >> (GROUP_SIZE - rem);
          end
          usable &= free_bits[g];
          if (usable == '0) continue;
          bit_i = 0;
          while (!usable[bit_i]) bit_i++;
          free_bits[g][bit_i] = 1'b0;
          if (free_bits[g] == '0) group_open[g] = 1'b0;
          r.gid = ID_W'(base + g * GROUP_SIZE + bit_i);  // wraps at 31 bits
          return r;
        end
        r.st = ST_FULL;
        return r;
      end
      // range check done without wrap
      if (rid < base || (rid - base) >= lim) begin
        r.st = ST_RANGE;
        return r;
      end
      off = rid - base;
      grp = off / GROUP_SIZE;
      bit_i = off % GROUP_SIZE;
      if (free_bits[grp][bit_i]) r.st = ST_NOT_TAKEN;
      else begin
        free_bits[grp][bit_i] = 1'b1;
        group_open[grp] = 1'b1;
      end
      return r;
    endfunction

    function void note_request(logic op, logic [ID_W-1:0] rid);
      grant_t e;
      e = allocate_or_free(op, rid);
      pending_grants.push_back(e);
      n_req++;
      case (e.st)
        ST_OK:        n_ok++;
        ST_FULL:      n_full++;
        ST_RANGE:     n_range++;
        ST_NOT_TAKEN: n_not_taken++;
        default: ;
      endcase
    endfunction

    function void check_grant(logic [ID_W-1:0] gid, logic [1:0] st);
      grant_t e;
      if (pending_grants.size() == 0) begin
        $error("result beat with nothing pending: granted_id %0h status %0d", gid, st);
        errors++;
        return;
      end
      e = pending_grants.pop_front();
      if (gid !== e.gid) begin
        $error("granted_id mismatch: expected %0h, actual %0h", e.gid, gid);
        errors++;
      end
      if (st !== e.st) begin
        $error("status mismatch: expected %0d (%s), actual %0d", e.st, e.st.name(), st);
        errors++;
      end
    endfunction
  endclass

  id_pool_model pool = new();
  int quiet_cycles;

  grouped_id_allocator_top #(
    .MAX_IDS   (MAX_IDS),
    .GROUP_SIZE(GROUP_SIZE)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_release_id (in_release_id),
    .out_valid     (out_valid),
    .out_granted_id(out_granted_id),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both checks read pre-edge values, so results land before the new request is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) pool.check_grant(out_granted_id, out_status);
      if (start && busy === 1'b0) pool.note_request(in_operation, in_release_id);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid === 1'b1 || (start && busy === 1'b0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Returns at the edge that accepts the beat; start stays high for the caller.
  task automatic send(input logic op, input logic [ID_W-1:0] rid, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_operation <= 1'($urandom);
      in_release_id <= ID_W'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_release_id <= rid;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pool.pending_grants.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic [ID_W-1:0] base, input logic [CNTC_W-1:0] count);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE_ID;
    cfg_wdata <= base;
    @(posedge clk);
    pool.set_register(CFG_BASE_ID, base);
    cfg_index <= CFG_ID_COUNT;
    cfg_wdata <= CFG_W'(count);
    @(posedge clk);
    pool.set_register(CFG_ID_COUNT, CFG_W'(count));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly ids near the managed range so releases hit taken and free slots alike.
  function automatic logic [ID_W-1:0] pick_release_id();
    int unsigned sel;
    logic [31:0] sum;
    sel = $urandom_range(99);
    if (sel < 75) begin
      sum = pool.base + $urandom_range(pool.span() + 1);
      return sum[ID_W-1:0];
    end
    if (sel < 88 && pool.base != 0) return ID_W'($urandom_range(pool.base - 1));
    return ID_W'($urandom);
  endfunction

  initial begin
    logic [ID_W-1:0]   ph_base [NUM_PHASES];
    logic [CNTC_W-1:0] ph_count [NUM_PHASES];
    int                ph_idle [NUM_PHASES];
    logic              op;

    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_GET;
    in_release_id = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_BASE_ID;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: lowest ids first, double release, bounds
    send(OP_GET, '0, 0);
    send(OP_GET, '1, 0);
    send(OP_GET, '0, 0);
    send(OP_RELEASE, 31'd1, 0);
    send(OP_RELEASE, 31'd1, 0);
    send(OP_GET, '0, 0);
    send(OP_RELEASE, 31'd1024, 0);
    send(OP_RELEASE, '1, 0);
    send(OP_RELEASE, 31'd0, 0);
    send(OP_RELEASE, 31'd2, 0);
    drain();

    // top base with oversized count: grants wrap past 31 bits
    configure('1, '1);
    send(OP_GET, '0, 0);
    send(OP_GET, '0, 0);
    send(OP_RELEASE, '1, 0);
    send(OP_RELEASE, 31'd0, 0);
    drain();

    // nothing managed
    configure(31'd100, 11'd0);
    send(OP_GET, '0, 0);
    send(OP_RELEASE, 31'd100, 0);
    drain();

    // single id
    configure('0, 11'd1);
    send(OP_GET, '0, 0);
    send(OP_GET, '0, 0);
    send(OP_RELEASE, 31'd0, 0);
    send(OP_RELEASE, 31'd1, 0);
    drain();

    ph_base[0] = 31'd1000;           ph_count[0] = 11'd40;   ph_idle[0] = 0;
    ph_base[1] = 31'h7fff_fff0;      ph_count[1] = 11'd64;   ph_idle[1] = 51;
    ph_base[2] = ID_W'($urandom);    ph_count[2] = 11'd2047; ph_idle[2] = 30;
    ph_base[3] = '0;                 ph_count[3] = 11'd33;   ph_idle[3] = 0;
    ph_base[4] = 31'd5;              ph_count[4] = 11'd8;    ph_idle[4] = 51;

    // map state carries over between settings on purpose
    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(ph_base[p], ph_count[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < 55) ? OP_GET : OP_RELEASE;
        send(op, (op == OP_GET) ? ID_W'($urandom) : pick_release_id(), ph_idle[p]);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d requests across %0d settings:", pool.n_req, NUM_PHASES + 4);
    $display("  %0d granted or freed, %0d full, %0d out of range, %0d not taken",
             pool.n_ok, pool.n_full, pool.n_range, pool.n_not_taken);
    if (pool.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
